// ===== hdl/hed_pkg.sv =====
// ----------------------------------------------------------------------------
// hed_pkg
// Shared constants, command item type and name tables of the entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam int PEND_DEPTH = 16;
  localparam int PEND_AW    = $clog2(PEND_DEPTH);
  localparam int CNT_W      = $clog2(PEND_DEPTH + 1);

  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  localparam int NAME_COUNT = 6;
  localparam logic [NAME_COUNT-1:0] ALL_NAMES = '1;

  localparam logic [7:0] CODE_CAP = 8'd128;

  localparam logic [1:0] MODE_PLAIN   = 2'd0;
  localparam logic [1:0] MODE_NAMED   = 2'd1;
  localparam logic [1:0] MODE_NUMERIC = 2'd2;

  // back-end actions
  localparam logic [1:0] ACT_EMIT   = 2'd0;  // emit byte as is
  localparam logic [1:0] ACT_DECODE = 2'd1;  // emit decoded byte, drop pending bytes
  localparam logic [1:0] ACT_PUSH   = 2'd2;  // append byte to pending bytes

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam logic [7:0] CH_X_UP = 8'h58;

  typedef struct packed {
    logic       flush;  // replay pending bytes before the action
    logic [1:0] act;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    fold_case = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  // lt gt amp quot apos nbsp, terminating semicolon included
  function automatic logic [2:0] ent_size(input logic [2:0] i);
    unique case (i)
      3'd0, 3'd1:       ent_size = 3'd3;
      3'd2:             ent_size = 3'd4;
      3'd3, 3'd4, 3'd5: ent_size = 3'd5;
      default:          ent_size = 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] name_char(input logic [2:0] i, input logic [2:0] pos);
    logic [39:0] s;
    s = '0;
    unique case (i)
      3'd0:    s = {8'h3B, 8'h74, 8'h6C, 16'h0000};            // ";tl"
      3'd1:    s = {8'h3B, 8'h74, 8'h67, 16'h0000};            // ";tg"
      3'd2:    s = {8'h3B, 8'h70, 8'h6D, 8'h61, 8'h00};        // ";pma"
      3'd3:    s = {8'h3B, 8'h74, 8'h6F, 8'h75, 8'h71};        // ";touq"
      3'd4:    s = {8'h3B, 8'h73, 8'h6F, 8'h70, 8'h61};        // ";sopa"
      3'd5:    s = {8'h3B, 8'h70, 8'h73, 8'h62, 8'h6E};        // ";psbn"
      default: s = '0;
    endcase
    // strings above are written last char first; pick char at pos
    unique case (ent_size(i))
      3'd3:    name_char = (pos < 3'd3) ? s[39 - 8*(2 - pos) -: 8] : 8'h00;
      3'd4:    name_char = (pos < 3'd4) ? s[39 - 8*(3 - pos) -: 8] : 8'h00;
      3'd5:    name_char = s[39 - 8*(4 - pos) -: 8];
      default: name_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] name_out(input logic [2:0] i);
    unique case (i)
      3'd0:    name_out = 8'h3C;
      3'd1:    name_out = 8'h3E;
      3'd2:    name_out = 8'h26;
      3'd3:    name_out = 8'h22;
      3'd4:    name_out = 8'h27;
      3'd5:    name_out = 8'h20;
      default: name_out = 8'h00;
    endcase
  endfunction

endpackage

// ===== hdl/hed_in_if.sv =====
// ----------------------------------------------------------------------------
// hed_in_if
// Input channel: one raw text byte per item.
// ----------------------------------------------------------------------------
interface hed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hdl/hed_out_if.sv =====
// ----------------------------------------------------------------------------
// hed_out_if
// Output channel: one decoded byte per item.
// ----------------------------------------------------------------------------
interface hed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hdl/html_entity_decoder_top.sv =====
// ----------------------------------------------------------------------------
// html_entity_decoder_top
// Streaming HTML entity decoder. An ordinary byte is taken every cycle while
// the command queue has room; its command is held in that queue and its
// result is registered at the output. Bytes of an open reference produce no
// result until it ends; a decoded reference yields one byte. A reference that
// fails is replayed from the pending byte buffer in the back end at one byte
// per cycle while the output is not stalled: the back end takes the command,
// replays the pending bytes (up to 16), then handles the breaking byte. A
// reference still open at the byte marked last is replayed after that byte.
// A four-entry command queue lets the input side run on while a replay or an
// output stall is in progress; input ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module html_entity_decoder_top (
  input  logic       clk,
  input  logic       rst,
  hed_in_if.sink     din,
  hed_out_if.source  dout
);

  hed_pkg::cmd_t fq_cmd, head;
  logic          fq_push, fq_full, pop, head_valid;

  hed_front u_front (
    .clk     (clk),
    .rst     (rst),
    .din     (din),
    .fq_full (fq_full),
    .fq_push (fq_push),
    .fq_cmd  (fq_cmd)
  );

  hed_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (fq_push),
    .push_cmd   (fq_cmd),
    .full       (fq_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  hed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .dout       (dout)
  );

endmodule

// ===== hdl/hed_front.sv =====
// ----------------------------------------------------------------------------
// hed_front
// Accepts text bytes, tracks the open reference and issues one command per item.
// ----------------------------------------------------------------------------
module hed_front (
  input  logic          clk,
  input  logic          rst,
  hed_in_if.sink        din,
  input  logic          fq_full,
  output logic          fq_push,
  output hed_pkg::cmd_t fq_cmd
);

  logic [1:0]                    mode, mode_next;
  logic [hed_pkg::NAME_COUNT-1:0] cand, cand_next;
  logic                          hex, hex_next;
  logic [7:0]                    code, code_next;
  logic                          seen, seen_next;
  logic [hed_pkg::CNT_W-1:0]     count, count_next;

  logic [7:0]  b, lb;
  logic        accept;
  logic        buf_full;
  logic [2:0]  pos;
  logic [hed_pkg::NAME_COUNT-1:0] match, hit_v;
  logic        complete;
  logic [2:0]  hit;
  logic [3:0]  dval;
  logic        dok;
  logic [10:0] scaled, sum;
  logic [7:0]  code_new;
  logic        done, decode, fail;
  logic [7:0]  dec_byte;

  assign b        = din.in_byte;
  assign lb       = hed_pkg::fold_case(b);
  assign din.ready = !fq_full;
  assign accept   = din.valid && din.ready;
  assign buf_full = count >= hed_pkg::CNT_W'(hed_pkg::PEND_DEPTH);
  assign pos      = 3'(count - hed_pkg::CNT_W'(1));

  always_comb begin
    complete = 1'b0;
    hit      = 3'd0;
    for (int i = 0; i < hed_pkg::NAME_COUNT; i++) begin
      match[i] = cand[i] && (pos < hed_pkg::ent_size(3'(i))) &&
                 (hed_pkg::name_char(3'(i), pos) == lb);
      hit_v[i] = match[i] && ((pos + 3'd1) == hed_pkg::ent_size(3'(i)));
    end
    for (int i = hed_pkg::NAME_COUNT - 1; i >= 0; i--) begin
      if (hit_v[i]) begin
        complete = 1'b1;
        hit      = 3'(i);
      end
    end
  end

  always_comb begin
    dok  = 1'b0;
    dval = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      dok  = 1'b1;
      dval = 4'(b - 8'h30);
    end else if (hex && lb >= 8'h61 && lb <= 8'h66) begin
      dok  = 1'b1;
      dval = 4'(lb - 8'h57);
    end
  end

  // value so far is below the cap here, so 7 bits carry it
  assign scaled = hex ? (11'(code[6:0]) << 4)
                      : ((11'(code[6:0]) << 3) + (11'(code[6:0]) << 1));
  assign sum    = scaled + 11'(dval);
  always_comb begin
    if (code >= hed_pkg::CODE_CAP)        code_new = code;
    else if (sum > 11'(hed_pkg::CODE_CAP)) code_new = hed_pkg::CODE_CAP;
    else                                   code_new = sum[7:0];
  end

  always_comb begin
    done       = 1'b0;
    decode     = 1'b0;
    dec_byte   = b;
    mode_next  = mode;
    cand_next  = cand;
    hex_next   = hex;
    code_next  = code;
    seen_next  = seen;
    count_next = count;

    if (mode == hed_pkg::MODE_NAMED) begin
      if (count == hed_pkg::CNT_W'(1) && b == hed_pkg::CH_HASH) begin
        if (!buf_full) begin
          done      = 1'b1;
          mode_next = hed_pkg::MODE_NUMERIC;
          cand_next = '0;
        end
      end else if (complete) begin
        done     = 1'b1;
        decode   = 1'b1;
        dec_byte = hed_pkg::name_out(hit);
      end else if (match != '0 && !buf_full) begin
        done      = 1'b1;
        cand_next = match;
      end
    end else if (mode == hed_pkg::MODE_NUMERIC) begin
      if (count == hed_pkg::CNT_W'(2) && !hex &&
          (b == hed_pkg::CH_X_LO || b == hed_pkg::CH_X_UP)) begin
        if (!buf_full) begin
          done     = 1'b1;
          hex_next = 1'b1;
        end
      end else if (b == hed_pkg::CH_SEMI) begin
        if (seen && code != 8'd0 && code < hed_pkg::CODE_CAP) begin
          done     = 1'b1;
          decode   = 1'b1;
          dec_byte = code;
        end
      end else if (dok && !buf_full) begin
        done      = 1'b1;
        seen_next = 1'b1;
        code_next = code_new;
      end
    end

    fail = (mode == hed_pkg::MODE_NAMED || mode == hed_pkg::MODE_NUMERIC) && !done;

    if (done && !decode) begin
      count_next = count + hed_pkg::CNT_W'(1);
    end else begin
      // reference closed: decoded, failed, or plain text
      mode_next  = hed_pkg::MODE_PLAIN;
      cand_next  = '0;
      hex_next   = 1'b0;
      code_next  = 8'd0;
      seen_next  = 1'b0;
      count_next = '0;
      if (!done && b == hed_pkg::CH_AMP) begin
        mode_next  = hed_pkg::MODE_NAMED;
        cand_next  = hed_pkg::ALL_NAMES;
        count_next = hed_pkg::CNT_W'(1);
      end
    end

    if (din.in_last) begin
      mode_next  = hed_pkg::MODE_PLAIN;
      cand_next  = '0;
      hex_next   = 1'b0;
      code_next  = 8'd0;
      seen_next  = 1'b0;
      count_next = '0;
    end
  end

  always_comb begin
    fq_cmd.flush = fail;
    fq_cmd.last  = din.in_last;
    fq_cmd.data  = decode ? dec_byte : b;
    if (done) fq_cmd.act = decode ? hed_pkg::ACT_DECODE : hed_pkg::ACT_PUSH;
    else      fq_cmd.act = (b == hed_pkg::CH_AMP) ? hed_pkg::ACT_PUSH : hed_pkg::ACT_EMIT;
  end

  assign fq_push = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= hed_pkg::MODE_PLAIN;
      cand  <= '0;
      hex   <= 1'b0;
      code  <= 8'd0;
      seen  <= 1'b0;
      count <= '0;
    end else if (accept) begin
      mode  <= mode_next;
      cand  <= cand_next;
      hex   <= hex_next;
      code  <= code_next;
      seen  <= seen_next;
      count <= count_next;
    end
  end

  // an open reference always holds its ampersand
  a_ref_has_count: assert property (@(posedge clk) disable iff (rst)
    (mode != hed_pkg::MODE_PLAIN) |-> (count != '0))
    else $error("open reference with no pending bytes");
  a_named_short: assert property (@(posedge clk) disable iff (rst)
    (mode == hed_pkg::MODE_NAMED) |-> (count <= hed_pkg::CNT_W'(5)))
    else $error("named reference longer than any name");
  a_plain_clear: assert property (@(posedge clk) disable iff (rst)
    (mode == hed_pkg::MODE_PLAIN) |-> (count == '0 && cand == '0))
    else $error("plain mode with leftover reference state");

endmodule

// ===== hdl/hed_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// hed_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hed_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hed_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output hed_pkg::cmd_t head,
  output logic          head_valid
);

  hed_pkg::cmd_t               slots [hed_pkg::FQ_DEPTH];
  logic [hed_pkg::FQ_AW-1:0]   wr_ptr, rd_ptr;
  logic [hed_pkg::FQ_CW-1:0]   fill;
  logic                        do_push, do_pop;

  assign full       = fill == hed_pkg::FQ_CW'(hed_pkg::FQ_DEPTH);
  assign head_valid = fill != '0;
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + hed_pkg::FQ_AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + hed_pkg::FQ_AW'(1);
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + hed_pkg::FQ_CW'(1);
        2'b01:   fill <= fill - hed_pkg::FQ_CW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/hed_back.sv =====
// ----------------------------------------------------------------------------
// hed_back
// Executes commands: keeps the pending bytes, replays them and emits results.
// ----------------------------------------------------------------------------
module hed_back (
  input  logic          clk,
  input  logic          rst,
  input  hed_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  hed_out_if.source     dout
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PRE  = 2'd1;  // replay before the action
  localparam logic [1:0] ST_ACT  = 2'd2;
  localparam logic [1:0] ST_POST = 2'd3;  // end-of-text replay

  logic [7:0]                pend [hed_pkg::PEND_DEPTH];
  logic [1:0]                st, st_next;
  logic [hed_pkg::CNT_W-1:0] idx, idx_next;
  logic [hed_pkg::CNT_W-1:0] bcount, bcount_next;
  hed_pkg::cmd_t             cur, cur_next, op;

  logic       ov, ol;
  logic [7:0] ob;
  logic       can_emit, act_go, wr_en;
  logic       emit, emit_last;
  logic [7:0] emit_byte;
  logic       idx_end;

  assign can_emit = !ov || dout.ready;
  assign op       = (st == ST_ACT) ? cur : head;
  assign act_go   = (st == ST_ACT) ||
                    (st == ST_IDLE && head_valid && !(head.flush && bcount != '0));
  assign idx_end  = (idx + hed_pkg::CNT_W'(1)) == bcount;

  always_comb begin
    st_next     = st;
    idx_next    = idx;
    bcount_next = bcount;
    cur_next    = cur;
    pop         = 1'b0;
    wr_en       = 1'b0;
    emit        = 1'b0;
    emit_last   = 1'b0;
    emit_byte   = 8'd0;

    unique case (st)
      ST_IDLE: begin
        if (head_valid && head.flush && bcount != '0) begin
          cur_next = head;
          pop      = 1'b1;
          idx_next = '0;
          st_next  = ST_PRE;
        end
      end
      ST_PRE: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = pend[idx[hed_pkg::PEND_AW-1:0]];
          idx_next  = idx + hed_pkg::CNT_W'(1);
          if (idx_end) begin
            bcount_next = '0;
            st_next     = ST_ACT;
          end
        end
      end
      ST_ACT: begin
      end
      ST_POST: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = pend[idx[hed_pkg::PEND_AW-1:0]];
          emit_last = idx_end;
          idx_next  = idx + hed_pkg::CNT_W'(1);
          if (idx_end) begin
            bcount_next = '0;
            st_next     = ST_IDLE;
          end
        end
      end
      default: st_next = ST_IDLE;
    endcase

    if (act_go) begin
      if (op.act == hed_pkg::ACT_PUSH) begin
        wr_en       = 1'b1;
        bcount_next = bcount + hed_pkg::CNT_W'(1);
        pop         = (st == ST_IDLE);
        if (op.last) begin
          idx_next = '0;
          st_next  = ST_POST;
        end else begin
          st_next = ST_IDLE;
        end
      end else if (can_emit) begin
        // plain byte or decoded reference: no pending bytes remain after it
        emit        = 1'b1;
        emit_byte   = op.data;
        emit_last   = op.last;
        bcount_next = '0;
        pop         = (st == ST_IDLE);
        st_next     = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) pend[bcount[hed_pkg::PEND_AW-1:0]] <= op.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= ST_IDLE;
      idx    <= '0;
      bcount <= '0;
      ov     <= 1'b0;
    end else begin
      st     <= st_next;
      idx    <= idx_next;
      bcount <= bcount_next;
      if (emit)            ov <= 1'b1;
      else if (dout.ready) ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (emit) begin
      ob <= emit_byte;
      ol <= emit_last;
    end
  end

  assign dout.valid    = ov;
  assign dout.out_byte = ob;
  assign dout.out_last = ol;

  a_bcount_bound: assert property (@(posedge clk) disable iff (rst)
    bcount <= hed_pkg::CNT_W'(hed_pkg::PEND_DEPTH))
    else $error("pending byte count beyond buffer depth");
  a_replay_in_range: assert property (@(posedge clk) disable iff (rst)
    (st == ST_PRE || st == ST_POST) |-> (idx < bcount))
    else $error("replay index past pending bytes");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |=> (bcount == '0 && st == ST_IDLE))
    else $error("pending bytes left after the final result");
  a_no_emit_stall: assert property (@(posedge clk) disable iff (rst)
    (ov && !dout.ready) |-> !emit)
    else $error("result overwritten while stalled");

endmodule

// ===== test/html_entity_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_entity_decoder_top_tb
// Self-checking bench for the streaming entity decoder. A short table of
// texts covers the byte extremes, named and numeric references and the
// literal replay of broken ones. Random texts follow: well-formed references
// with random case and content, mixed with broken references, long
// leading-zero runs, plain text and raw bytes. Directed texts carry their
// expected output, an in-bench decoder predicts that of the random texts;
// the sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module html_entity_decoder_top_tb;

  localparam int RANDOM_ITEMS = 480;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } dec_t;

  // directed text; an empty text sends the single byte in solo
  typedef struct {
    string      text;
    logic [7:0] solo;
    bit         typed;
    string      want;
  } drow_t;

  typedef enum int {RX_OPEN, RX_SPOTTY, RX_BLOCKS} rx_mode_t;

  logic clk;
  logic rst;

  hed_in_if  din ();
  hed_out_if dout ();

  html_entity_decoder_top i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  // decoder state mirror
  logic [7:0]                     pend_buf [hed_pkg::PEND_DEPTH];
  int                             pend_cnt;
  logic [1:0]                     ref_mode;
  logic [hed_pkg::NAME_COUNT-1:0] name_live;
  bit                             hex_ref;
  int                             code_acc;
  bit                             got_digit;

  string      ent_names [hed_pkg::NAME_COUNT] =
    '{"lt;", "gt;", "amp;", "quot;", "apos;", "nbsp;"};
  logic [7:0] ent_chars [hed_pkg::NAME_COUNT] =
    '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27, 8'h20};

  dec_t       decoded_q [$];
  logic [7:0] text_q [$];

  int step_emits;
  bit step_record;

  int err_cnt;
  int items_sent;
  int texts_sent;
  int results_checked;
  int named_hits;
  int numeric_hits;
  int replays;
  int burst_left;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  drow_t dir_rows [9] = '{
    '{"",       8'h00, 1'b1, ""},
    '{"\377",   8'h00, 1'b1, "\377"},
    '{"&lt;",   8'h00, 1'b1, "<"},
    '{"&#39;",  8'h00, 1'b1, "'"},
    '{"&#0;",   8'h00, 1'b1, "&#0;"},
    '{"&#;",    8'h00, 1'b1, "&#;"},
    '{"&#x80;", 8'h00, 1'b1, "&#x80;"},
    '{"&Q",     8'h00, 1'b1, "&Q"},
    '{"&&",     8'h00, 1'b1, "&&"}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void put_result(logic [7:0] b);
    step_emits++;
    if (step_record) decoded_q.push_back('{b, 1'b0});
  endfunction

  function automatic void drop_ref();
    pend_cnt  = 0;
    ref_mode  = hed_pkg::MODE_PLAIN;
    name_live = '0;
    hex_ref   = 1'b0;
    code_acc  = 0;
    got_digit = 1'b0;
  endfunction

  function automatic void replay_ref();
    if (pend_cnt > 0) replays++;
    for (int i = 0; i < pend_cnt; i++) put_result(pend_buf[i]);
    drop_ref();
  endfunction

  // false when the buffer was full; the pending bytes are replayed then
  function automatic bit hold_byte(logic [7:0] b);
    if (pend_cnt >= hed_pkg::PEND_DEPTH) begin
      replay_ref();
      return 1'b0;
    end
    pend_buf[pend_cnt] = b;
    pend_cnt++;
    return 1'b1;
  endfunction

  function automatic int digit_val(logic [7:0] b, bit hex);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (hex && b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (hex && b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic bit match_name(logic [7:0] b);
    int                             pos;
    logic [hed_pkg::NAME_COUNT-1:0] keep;
    logic [7:0]                     lb;
    pos  = pend_cnt - 1;
    keep = '0;
    lb   = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    if (pend_cnt == 1 && b == hed_pkg::CH_HASH) begin
      void'(hold_byte(b));
      ref_mode  = hed_pkg::MODE_NUMERIC;
      name_live = '0;
      return 1'b1;
    end
    for (int i = 0; i < hed_pkg::NAME_COUNT; i++) begin
      if (name_live[i] && pos < ent_names[i].len() && ent_names[i][pos] == lb) begin
        if (pos + 1 == ent_names[i].len()) begin
          put_result(ent_chars[i]);
          drop_ref();
          named_hits++;
          return 1'b1;
        end
        keep[i] = 1'b1;
      end
    end
    if (keep == '0) begin
      replay_ref();
      return 1'b0;
    end
    if (!hold_byte(b)) return 1'b0;
    name_live = keep;
    return 1'b1;
  endfunction

  function automatic bit match_numeric(logic [7:0] b);
    int d;
    if (pend_cnt == 2 && !hex_ref && (b == hed_pkg::CH_X_LO || b == hed_pkg::CH_X_UP)) begin
      if (!hold_byte(b)) return 1'b0;
      hex_ref = 1'b1;
      return 1'b1;
    end
    if (b == hed_pkg::CH_SEMI) begin
      if (got_digit && code_acc >= 1 && code_acc < hed_pkg::CODE_CAP) begin
        put_result(code_acc[7:0]);
        drop_ref();
        numeric_hits++;
        return 1'b1;
      end
      replay_ref();
      return 1'b0;
    end
    d = digit_val(b, hex_ref);
    if (d < 0) begin
      replay_ref();
      return 1'b0;
    end
    if (!hold_byte(b)) return 1'b0;
    got_digit = 1'b1;
    // value saturates at the cap, so long digit runs stay bounded
    if (code_acc < hed_pkg::CODE_CAP) begin
      code_acc = code_acc * (hex_ref ? 16 : 10) + d;
      if (code_acc > hed_pkg::CODE_CAP) code_acc = hed_pkg::CODE_CAP;
    end
    return 1'b1;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last, bit record);
    bit done;
    done        = 1'b0;
    step_emits  = 0;
    step_record = record;
    if (ref_mode == hed_pkg::MODE_NAMED) done = match_name(b);
    else if (ref_mode == hed_pkg::MODE_NUMERIC) done = match_numeric(b);
    if (!done) begin
      // breaking byte is handled again as plain text
      if (ref_mode != hed_pkg::MODE_PLAIN) drop_ref();
      if (b == hed_pkg::CH_AMP) begin
        pend_buf[0] = b;
        pend_cnt    = 1;
        ref_mode    = hed_pkg::MODE_NAMED;
        name_live   = hed_pkg::ALL_NAMES;
      end else begin
        put_result(b);
      end
    end
    if (last) begin
      replay_ref();
      if (record && step_emits > 0) decoded_q[$].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int pick_code();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 0 : $urandom_range(128, 4095);
      default: return $urandom_range(1, 127);
    endcase
  endfunction

  function automatic string zero_run(int n);
    string s;
    s = "";
    repeat (n) s = {s, "0"};
    return s;
  endfunction

  function automatic string entity_text();
    string      s;
    string      digs;
    string      xs;
    int         i;
    logic [7:0] c;
    case ($urandom_range(0, 2))
      0: begin
        i = $urandom_range(0, hed_pkg::NAME_COUNT - 1);
        s = "&";
        for (int j = 0; j < ent_names[i].len(); j++) begin
          c = ent_names[i][j];
          if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
          s = $sformatf("%s%c", s, c);
        end
      end
      1: begin
        digs = $sformatf("%0d", pick_code());
        s = {"&#", zero_run($urandom_range(0, 2)), digs, ";"};
      end
      default: begin
        digs = $sformatf("%0h", pick_code());
        if ($urandom_range(0, 1)) digs = digs.toupper();
        xs = $urandom_range(0, 1) ? "x" : "X";
        s = {"&#", xs, zero_run($urandom_range(0, 2)), digs, ";"};
      end
    endcase
    return s;
  endfunction

  function automatic void push_string(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void add_fragment();
    string s;
    int    cut;
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: push_string(entity_text());
      5, 6: begin
        s   = entity_text();
        cut = $urandom_range(1, s.len() - 1);
        push_string(s.substr(0, cut - 1));
        case ($urandom_range(0, 3))
          0:       text_q.push_back(hed_pkg::CH_AMP);
          1:       text_q.push_back(hed_pkg::CH_SEMI);
          2:       text_q.push_back(8'h20);
          default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      // long leading-zero runs; from 13 zeros on they overrun the pending buffer
      7: push_string({"&#", zero_run($urandom_range(12, 17)), "65;"});
      8, 9: repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(32, 126)));
      10: repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
      default: begin
        case ($urandom_range(0, 4))
          0:       push_string("&#;");
          1:       push_string("&#x;");
          2:       push_string("&");
          3:       push_string("&#");
          default: push_string("&#x");
        endcase
      end
    endcase
  endfunction

  function automatic void push_typed(string w, logic [7:0] solo);
    if (w.len() == 0) begin
      decoded_q.push_back('{solo, 1'b1});
    end else begin
      for (int i = 0; i < w.len(); i++) decoded_q.push_back('{w[i], i == w.len() - 1});
    end
  endfunction

  // bursts of random length, random gaps in between
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        din.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  task automatic push_byte(logic [7:0] b, logic last, bit record);
    din.valid   <= 1'b1;
    din.in_byte <= b;
    din.in_last <= last;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    decode_byte(b, last, record);
    items_sent++;
  endtask

  task automatic send_text(bit record);
    for (int i = 0; i < text_q.size(); i++) begin
      pace_sender();
      push_byte(text_q[i], i == text_q.size() - 1, record);
    end
    texts_sent++;
  endtask

  initial begin : stimulus
    rst         = 1'b1;
    din.valid   = 1'b0;
    din.in_byte = '0;
    din.in_last = 1'b0;
    dout.ready  = 1'b0;
    drop_ref();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      text_q.delete();
      if (dir_rows[r].text.len() == 0) text_q.push_back(dir_rows[r].solo);
      else push_string(dir_rows[r].text);
      if (dir_rows[r].typed) push_typed(dir_rows[r].want, dir_rows[r].solo);
      send_text(!dir_rows[r].typed);
    end

    while (items_sent < RANDOM_ITEMS) begin
      text_q.delete();
      repeat ($urandom_range(1, 5)) add_fragment();
      send_text(1'b1);
    end
    din.valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    // a late replay would show up here as an unexpected item
    repeat (40) @(posedge clk);

    $display("%0d input items in %0d texts, %0d output items checked",
             items_sent, texts_sent, results_checked);
    $display("%0d named and %0d numeric references decoded, %0d literal replays",
             named_hits, numeric_hits, replays);
    if (err_cnt == 0) begin
      $display("html_entity_decoder_top_tb passed");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("html_entity_decoder_top_tb failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(4, 40);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   dout.ready <= 1'b1;
      RX_SPOTTY: dout.ready <= ($urandom_range(0, 3) != 0);
      default:   dout.ready <= rx_left[3];
    endcase
  end

  function automatic void log_fail(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t ERROR %s", $time, msg);
  endfunction

  always @(posedge clk) begin : out_check
    dec_t head;
    if (!rst && dout.valid && dout.ready) begin
      if (decoded_q.size() == 0) begin
        log_fail($sformatf("unexpected item byte %h last %b", dout.out_byte, dout.out_last));
      end else begin
        head = decoded_q.pop_front();
        results_checked++;
        if (dout.out_byte !== head.data)
          log_fail($sformatf("out_byte exp %h got %h", head.data, dout.out_byte));
        if (dout.out_last !== head.last)
          log_fail($sformatf("out_last exp %b got %b (byte %h)",
                             head.last, dout.out_last, head.data));
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("timeout: %0d items sent, %0d outputs outstanding", items_sent, decoded_q.size());
    $display("html_entity_decoder_top_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hed_pkg.sv
hdl/hed_in_if.sv
hdl/hed_out_if.sv
hdl/hed_front.sv
hdl/hed_cmd_fifo.sv
hdl/hed_back.sv
hdl/html_entity_decoder_top.sv
test/html_entity_decoder_top_tb.sv
